// File: rtl/ssi_pkg.sv
// ---------------------------------------------------------------------------
// ssi_pkg
// shared constants of the segment intersection pipeline
// ---------------------------------------------------------------------------
package ssi_pkg;

    // coordinate fields packed into one input word
    localparam int N_FIELDS = 8;

    // output word width: one flag padded to a byte
    localparam int OUT_TDATA_W = 8;

    // register stages from input to output word
    localparam int LATENCY = 5;

endpackage

// File: rtl/segment_segment_intersection_test.sv
// path: an accepted input word passes the sub, prod, cross, norm and decide registers
// throughput: one word per cycle while m_tready is high; each of the five stages holds one word
// stalls: every stage advances when it is empty or its successor moves on
// reset: rst_n asynchronous, active low, empties all stages; no other state
// ---------------------------------------------------------------------------
// segment_segment_intersection_test
// tests whether two line segments with signed integer endpoints intersect,
// using exact integer cross products instead of a division
// ---------------------------------------------------------------------------
module segment_segment_intersection_test #(
    parameter int COORD_BITS = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // input stream
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // from bit 0: seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
    //             seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y
    input  logic [ssi_pkg::N_FIELDS*COORD_BITS-1:0]    s_tdata,
    // output stream
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // from bit 0: intersects, then zero padding
    output logic [ssi_pkg::OUT_TDATA_W-1:0]            m_tdata
);

    localparam int DW = COORD_BITS + 1;        // difference width
    localparam int PW = 2 * DW;                // product width
    localparam int CW = PW + 1;                // cross product width

    // unpack the endpoint fields
    logic signed [COORD_BITS-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

    assign ax0 = s_tdata[0*COORD_BITS +: COORD_BITS];
    assign ay0 = s_tdata[1*COORD_BITS +: COORD_BITS];
    assign ax1 = s_tdata[2*COORD_BITS +: COORD_BITS];
    assign ay1 = s_tdata[3*COORD_BITS +: COORD_BITS];
    assign bx0 = s_tdata[4*COORD_BITS +: COORD_BITS];
    assign by0 = s_tdata[5*COORD_BITS +: COORD_BITS];
    assign bx1 = s_tdata[6*COORD_BITS +: COORD_BITS];
    assign by1 = s_tdata[7*COORD_BITS +: COORD_BITS];

    // stage 1 -> 2: direction vectors and start offset
    logic                 v1, r1;
    logic signed [DW-1:0] adx, ady, bdx, bdy, cx, cy;

    // stage 2 -> 3: partial products
    logic                 v2, r2;
    logic signed [PW-1:0] p_d0, p_d1, p_t0, p_t1, p_u0, p_u1;

    // stage 3 -> 4: denominator and both numerators
    logic                 v3, r3;
    logic signed [CW-1:0] d, tn, un;

    // stage 4 -> 5: values with a non-negative denominator
    logic                 v4, r4;
    logic                 nz;
    logic signed [CW-1:0] d_pos, tn_adj, un_adj;

    logic                 intersects;

    ssi_sub #(
        .COORD_BITS (COORD_BITS)
    ) u_sub (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .ax0       (ax0),
        .ay0       (ay0),
        .ax1       (ax1),
        .ay1       (ay1),
        .bx0       (bx0),
        .by0       (by0),
        .bx1       (bx1),
        .by1       (by1),
        .out_valid (v1),
        .out_ready (r1),
        .adx       (adx),
        .ady       (ady),
        .bdx       (bdx),
        .bdy       (bdy),
        .cx        (cx),
        .cy        (cy)
    );

    ssi_prod #(
        .COORD_BITS (COORD_BITS)
    ) u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in_ready  (r1),
        .adx       (adx),
        .ady       (ady),
        .bdx       (bdx),
        .bdy       (bdy),
        .cx        (cx),
        .cy        (cy),
        .out_valid (v2),
        .out_ready (r2),
        .p_d0      (p_d0),
        .p_d1      (p_d1),
        .p_t0      (p_t0),
        .p_t1      (p_t1),
        .p_u0      (p_u0),
        .p_u1      (p_u1)
    );

    ssi_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .in_ready  (r2),
        .p_d0      (p_d0),
        .p_d1      (p_d1),
        .p_t0      (p_t0),
        .p_t1      (p_t1),
        .p_u0      (p_u0),
        .p_u1      (p_u1),
        .out_valid (v3),
        .out_ready (r3),
        .d         (d),
        .tn        (tn),
        .un        (un)
    );

    ssi_norm #(
        .COORD_BITS (COORD_BITS)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3),
        .in_ready  (r3),
        .d         (d),
        .tn        (tn),
        .un        (un),
        .out_valid (v4),
        .out_ready (r4),
        .nz        (nz),
        .d_pos     (d_pos),
        .tn_adj    (tn_adj),
        .un_adj    (un_adj)
    );

    // last stage doubles as the output register
    ssi_decide #(
        .COORD_BITS (COORD_BITS)
    ) u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v4),
        .in_ready   (r4),
        .nz         (nz),
        .d_pos      (d_pos),
        .tn_adj     (tn_adj),
        .un_adj     (un_adj),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .intersects (intersects)
    );

    // flag in bit 0, the rest of the byte is zero
    assign m_tdata = {{(ssi_pkg::OUT_TDATA_W-1){1'b0}}, intersects};

endmodule

// File: rtl/ssi_sub.sv
// ---------------------------------------------------------------------------
// ssi_sub
// stage 1: direction vectors of both segments and the start offset
// ---------------------------------------------------------------------------
module ssi_sub #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] ax0,
    input  logic signed [COORD_BITS-1:0] ay0,
    input  logic signed [COORD_BITS-1:0] ax1,
    input  logic signed [COORD_BITS-1:0] ay1,
    input  logic signed [COORD_BITS-1:0] bx0,
    input  logic signed [COORD_BITS-1:0] by0,
    input  logic signed [COORD_BITS-1:0] bx1,
    input  logic signed [COORD_BITS-1:0] by1,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS:0]   adx,
    output logic signed [COORD_BITS:0]   ady,
    output logic signed [COORD_BITS:0]   bdx,
    output logic signed [COORD_BITS:0]   bdy,
    output logic signed [COORD_BITS:0]   cx,
    output logic signed [COORD_BITS:0]   cy
);

    localparam int DW = COORD_BITS + 1;

    logic                 valid_reg;
    logic                 adv;
    logic signed [DW-1:0] adx_reg, ady_reg, bdx_reg, bdy_reg, cx_reg, cy_reg;
    logic signed [DW-1:0] adx_next, ady_next, bdx_next, bdy_next, cx_next, cy_next;

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    assign adx_next = {ax0[COORD_BITS-1], ax0} - {ax1[COORD_BITS-1], ax1};
    assign ady_next = {ay0[COORD_BITS-1], ay0} - {ay1[COORD_BITS-1], ay1};
    assign bdx_next = {bx0[COORD_BITS-1], bx0} - {bx1[COORD_BITS-1], bx1};
    assign bdy_next = {by0[COORD_BITS-1], by0} - {by1[COORD_BITS-1], by1};
    assign cx_next  = {ax0[COORD_BITS-1], ax0} - {bx0[COORD_BITS-1], bx0};
    assign cy_next  = {ay0[COORD_BITS-1], ay0} - {by0[COORD_BITS-1], by0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            adx_reg <= adx_next;
            ady_reg <= ady_next;
            bdx_reg <= bdx_next;
            bdy_reg <= bdy_next;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
        end
    end

    assign out_valid = valid_reg;
    assign adx       = adx_reg;
    assign ady       = ady_reg;
    assign bdx       = bdx_reg;
    assign bdy       = bdy_reg;
    assign cx        = cx_reg;
    assign cy        = cy_reg;

endmodule

// File: rtl/ssi_prod.sv
// ---------------------------------------------------------------------------
// ssi_prod
// stage 2: the six partial products of the three cross products
// ---------------------------------------------------------------------------
module ssi_prod #(
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [COORD_BITS:0]       adx,
    input  logic signed [COORD_BITS:0]       ady,
    input  logic signed [COORD_BITS:0]       bdx,
    input  logic signed [COORD_BITS:0]       bdy,
    input  logic signed [COORD_BITS:0]       cx,
    input  logic signed [COORD_BITS:0]       cy,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [2*COORD_BITS+1:0]   p_d0,
    output logic signed [2*COORD_BITS+1:0]   p_d1,
    output logic signed [2*COORD_BITS+1:0]   p_t0,
    output logic signed [2*COORD_BITS+1:0]   p_t1,
    output logic signed [2*COORD_BITS+1:0]   p_u0,
    output logic signed [2*COORD_BITS+1:0]   p_u1
);

    localparam int PW = 2 * (COORD_BITS + 1);

    logic                 valid_reg;
    logic                 adv;
    logic signed [PW-1:0] p_d0_reg, p_d1_reg, p_t0_reg, p_t1_reg, p_u0_reg, p_u1_reg;
    logic signed [PW-1:0] p_d0_next, p_d1_next, p_t0_next, p_t1_next, p_u0_next, p_u1_next;

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    // d = adx*bdy - ady*bdx, tn = cx*bdy - cy*bdx, un = ady*cx - adx*cy
    assign p_d0_next = adx * bdy;
    assign p_d1_next = ady * bdx;
    assign p_t0_next = cx * bdy;
    assign p_t1_next = cy * bdx;
    assign p_u0_next = ady * cx;
    assign p_u1_next = adx * cy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            p_d0_reg <= p_d0_next;
            p_d1_reg <= p_d1_next;
            p_t0_reg <= p_t0_next;
            p_t1_reg <= p_t1_next;
            p_u0_reg <= p_u0_next;
            p_u1_reg <= p_u1_next;
        end
    end

    assign out_valid = valid_reg;
    assign p_d0      = p_d0_reg;
    assign p_d1      = p_d1_reg;
    assign p_t0      = p_t0_reg;
    assign p_t1      = p_t1_reg;
    assign p_u0      = p_u0_reg;
    assign p_u1      = p_u1_reg;

endmodule

// File: rtl/ssi_cross.sv
// ---------------------------------------------------------------------------
// ssi_cross
// stage 3: cross product differences d, tn and un
// ---------------------------------------------------------------------------
module ssi_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [2*COORD_BITS+1:0]   p_d0,
    input  logic signed [2*COORD_BITS+1:0]   p_d1,
    input  logic signed [2*COORD_BITS+1:0]   p_t0,
    input  logic signed [2*COORD_BITS+1:0]   p_t1,
    input  logic signed [2*COORD_BITS+1:0]   p_u0,
    input  logic signed [2*COORD_BITS+1:0]   p_u1,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [2*COORD_BITS+2:0]   d,
    output logic signed [2*COORD_BITS+2:0]   tn,
    output logic signed [2*COORD_BITS+2:0]   un
);

    localparam int PW = 2 * (COORD_BITS + 1);
    localparam int CW = PW + 1;

    logic                 valid_reg;
    logic                 adv;
    logic signed [CW-1:0] d_reg, tn_reg, un_reg;
    logic signed [CW-1:0] d_next, tn_next, un_next;

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    assign d_next  = {p_d0[PW-1], p_d0} - {p_d1[PW-1], p_d1};
    assign tn_next = {p_t0[PW-1], p_t0} - {p_t1[PW-1], p_t1};
    assign un_next = {p_u0[PW-1], p_u0} - {p_u1[PW-1], p_u1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            d_reg  <= d_next;
            tn_reg <= tn_next;
            un_reg <= un_next;
        end
    end

    assign out_valid = valid_reg;
    assign d         = d_reg;
    assign tn        = tn_reg;
    assign un        = un_reg;

endmodule

// File: rtl/ssi_norm.sv
// ---------------------------------------------------------------------------
// ssi_norm
// stage 4: flip all signs when d is negative, so the denominator is zero or positive
// ---------------------------------------------------------------------------
module ssi_norm #(
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [2*COORD_BITS+2:0]   d,
    input  logic signed [2*COORD_BITS+2:0]   tn,
    input  logic signed [2*COORD_BITS+2:0]   un,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             nz,
    output logic signed [2*COORD_BITS+2:0]   d_pos,
    output logic signed [2*COORD_BITS+2:0]   tn_adj,
    output logic signed [2*COORD_BITS+2:0]   un_adj
);

    localparam int CW = 2 * (COORD_BITS + 1) + 1;

    logic                 valid_reg;
    logic                 adv;
    logic                 neg;
    logic                 nz_reg, nz_next;
    logic signed [CW-1:0] d_reg, tn_reg, un_reg;
    logic signed [CW-1:0] d_next, tn_next, un_next;

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    // magnitudes stay well below the top bit, so negation cannot overflow
    assign neg     = d[CW-1];
    assign nz_next = (d != '0);
    assign d_next  = neg ? -d  : d;
    assign tn_next = neg ? -tn : tn;
    assign un_next = neg ? -un : un;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            nz_reg <= nz_next;
            d_reg  <= d_next;
            tn_reg <= tn_next;
            un_reg <= un_next;
        end
    end

    assign out_valid = valid_reg;
    assign nz        = nz_reg;
    assign d_pos     = d_reg;
    assign tn_adj    = tn_reg;
    assign un_adj    = un_reg;

endmodule

// File: rtl/ssi_decide.sv
// ---------------------------------------------------------------------------
// ssi_decide
// stage 5: range checks 0 <= tn <= d and 0 <= un <= d with d nonzero, output register
// ---------------------------------------------------------------------------
module ssi_decide #(
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             nz,
    input  logic signed [2*COORD_BITS+2:0]   d_pos,
    input  logic signed [2*COORD_BITS+2:0]   tn_adj,
    input  logic signed [2*COORD_BITS+2:0]   un_adj,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             intersects
);

    logic valid_reg;
    logic adv;
    logic hit_reg, hit_next;

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    assign hit_next = nz
                   && (tn_adj >= 0) && (tn_adj <= d_pos)
                   && (un_adj >= 0) && (un_adj <= d_pos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid  = valid_reg;
    assign intersects = hit_reg;

endmodule

// File: rtl/ssi_check.sv
// ---------------------------------------------------------------------------
// ssi_check
// port-level checks of the segment intersection block, bound to the top
// ---------------------------------------------------------------------------
module ssi_check (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ssi_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed or dropped");

    // padding above the flag stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[ssi_pkg::OUT_TDATA_W-1:1] == '0))
    else $error("nonzero padding in result word");

    // with the output register empty every stage can move, so input is open
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input blocked while the output is empty");

    // free-flowing output gives the result exactly after the pipeline depth
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(s_acc, ssi_pkg::LATENCY) && $past(rst_n, ssi_pkg::LATENCY)
        && $past(rst_n, 4) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)
        && $past(m_tready, 4) && $past(m_tready, 3)
        && $past(m_tready, 2) && $past(m_tready, 1)
        |-> m_tvalid)
    else $error("result word missing after pipeline latency");

endmodule

bind segment_segment_intersection_test ssi_check u_ssi_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
